### hw/rtl/vsps_pkg.sv
// Shared types, constants and the constant table for the source prefix swizzle.
`default_nettype none
package vsps_pkg;

	localparam int LANE_COUNT = 4;
	localparam int LANE_W     = 32;
	localparam int PREFIX_W   = 20;
	localparam int SIZE_W     = 3;
	localparam int SEL_W      = 2;
	localparam int CIDX_W     = 3;

	// Field offsets inside the prefix word.
	localparam int ABS_LSB = 8;
	localparam int CST_LSB = 12;
	localparam int NEG_LSB = 16;

	localparam logic [LANE_W-1:0] SIGN_BIT = 32'h8000_0000;

	typedef logic [LANE_COUNT-1:0][LANE_W-1:0] lane_vec_t;

	typedef struct packed {
		logic              active;
		logic              cst;
		logic [SEL_W-1:0]  sel;
		logic [CIDX_W-1:0] cidx;
		logic              ab;
		logic              neg;
	} lane_ctrl_t;

	// Constants as IEEE single bit patterns: 0, 1, 2, 1/2, 3, 1/3, 1/4, 1/6.
	function automatic logic [LANE_W-1:0] const_value(input logic [CIDX_W-1:0] idx);
		logic [LANE_W-1:0] v;
		case (idx)
			3'd0: v = 32'h0000_0000;
			3'd1: v = 32'h3F80_0000;
			3'd2: v = 32'h4000_0000;
			3'd3: v = 32'h3F00_0000;
			3'd4: v = 32'h4040_0000;
			3'd5: v = 32'h3EAA_AAAB;
			3'd6: v = 32'h3E80_0000;
			3'd7: v = 32'h3E2A_AAAB;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/vector_source_prefix_swizzle_core.sv
// Top level of the vector source prefix swizzle pipeline.
// An input transfer passes the input, decode, pick and negate registers in that order to its result.
// Throughput: one item per cycle while no result is held; all four stages move together.
// A stalled result freezes the whole pipeline and stalls the input side.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none
module vector_source_prefix_swizzle_core
	import vsps_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_stall,
	input  wire logic [PREFIX_W-1:0] prefix_word,
	input  wire logic [SIZE_W-1:0]   vector_size,
	input  wire logic [LANE_W-1:0]   lane_x,
	input  wire logic [LANE_W-1:0]   lane_y,
	input  wire logic [LANE_W-1:0]   lane_z,
	input  wire logic [LANE_W-1:0]   lane_w,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output logic [LANE_W-1:0]        out_x,
	output logic [LANE_W-1:0]        out_y,
	output logic [LANE_W-1:0]        out_z,
	output logic [LANE_W-1:0]        out_w
);

	logic                        adv;
	logic                        valid_s1;
	logic                        valid_s2;
	logic                        valid_s3;
	logic                        valid_s4;
	logic [PREFIX_W-1:0]         prefix_s1;
	logic [SIZE_W-1:0]           size_s1;
	lane_vec_t                   src_s1;
	lane_vec_t                   src_s2;
	lane_ctrl_t [LANE_COUNT-1:0] ctrl_s2;
	lane_vec_t                   res_s4;

	// The pipeline moves unless a finished result is held by the receiver.
	assign adv       = !(valid_s4 && res_stall);
	assign src_stall = !adv;
	assign res_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prefix_s1 <= prefix_word;
			size_s1   <= vector_size;
			src_s1    <= {lane_w, lane_z, lane_y, lane_x};
		end
	end

	vsps_decode u_decode (
		.clk       (clk),
		.en        (adv),
		.prefix_s1 (prefix_s1),
		.size_s1   (size_s1),
		.src_s1    (src_s1),
		.ctrl_s2   (ctrl_s2),
		.src_s2    (src_s2)
	);

	for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
		vsps_lane u_lane (
			.clk     (clk),
			.en      (adv),
			.ctrl_s2 (ctrl_s2[g]),
			.src_s2  (src_s2),
			.own_s2  (src_s2[g]),
			.res_s4  (res_s4[g])
		);
	end

	assign out_x = res_s4[0];
	assign out_y = res_s4[1];
	assign out_z = res_s4[2];
	assign out_w = res_s4[3];

endmodule
`default_nettype wire

### hw/rtl/vsps_decode.sv
// Second pipeline stage: decodes the prefix word into per-lane control.
`default_nettype none
module vsps_decode
	import vsps_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [PREFIX_W-1:0] prefix_s1,
	input  wire logic [SIZE_W-1:0]   size_s1,
	input  wire lane_vec_t           src_s1,
	output lane_ctrl_t [LANE_COUNT-1:0] ctrl_s2,
	output lane_vec_t                src_s2
);

	localparam logic [SIZE_W-1:0] MaxSize = SIZE_W'(LANE_COUNT);

	logic [SIZE_W-1:0]               n_eff;
	lane_ctrl_t [LANE_COUNT-1:0]     ctrl_d;

	assign n_eff = (size_s1 > MaxSize) ? MaxSize : size_s1;

	always_comb begin
		for (int i = 0; i < LANE_COUNT; i++) begin
			logic [SEL_W-1:0] sel_raw;
			sel_raw          = prefix_s1[SEL_W*i +: SEL_W];
			ctrl_d[i].active = (SIZE_W'(i) < n_eff);
			ctrl_d[i].cst    = prefix_s1[CST_LSB + i];
			ctrl_d[i].ab     = prefix_s1[ABS_LSB + i];
			ctrl_d[i].neg    = prefix_s1[NEG_LSB + i];
			ctrl_d[i].cidx   = {prefix_s1[ABS_LSB + i], sel_raw};
			// A source selector past the active size falls back to lane 0.
			ctrl_d[i].sel    = ({1'b0, sel_raw} >= n_eff) ? '0 : sel_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s2 <= ctrl_d;
			src_s2  <= src_s1;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/vsps_lane.sv
// Third and fourth pipeline stages of one lane: source, constant or own-lane pick with abs, then negate.
`default_nettype none
module vsps_lane
	import vsps_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire lane_ctrl_t        ctrl_s2,
	input  wire lane_vec_t         src_s2,
	input  wire logic [LANE_W-1:0] own_s2,
	output logic [LANE_W-1:0]      res_s4
);

	logic [LANE_W-1:0] pick;
	logic [LANE_W-1:0] val_s3;
	logic              neg_s3;

	always_comb begin
		if (!ctrl_s2.active) begin
			pick = own_s2;
		end else if (ctrl_s2.cst) begin
			pick = const_value(ctrl_s2.cidx);
		end else if (ctrl_s2.ab) begin
			pick = src_s2[ctrl_s2.sel] & ~SIGN_BIT;
		end else begin
			pick = src_s2[ctrl_s2.sel];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s3 <= pick;
			neg_s3 <= ctrl_s2.active & ctrl_s2.neg;
			res_s4 <= neg_s3 ? (val_s3 ^ SIGN_BIT) : val_s3;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/vsps_checker.sv
// Port-level checks for the swizzle pipeline, bound to the top level.
`default_nettype none
module vsps_checker
	import vsps_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                src_valid,
	input wire logic                src_stall,
	input wire logic [PREFIX_W-1:0] prefix_word,
	input wire logic [SIZE_W-1:0]   vector_size,
	input wire logic [LANE_W-1:0]   lane_x,
	input wire logic [LANE_W-1:0]   lane_y,
	input wire logic [LANE_W-1:0]   lane_z,
	input wire logic [LANE_W-1:0]   lane_w,
	input wire logic                res_valid,
	input wire logic                res_stall,
	input wire logic [LANE_W-1:0]   out_x,
	input wire logic [LANE_W-1:0]   out_y,
	input wire logic [LANE_W-1:0]   out_z,
	input wire logic [LANE_W-1:0]   out_w
);

	// A held result keeps its lanes.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(out_w))
		else $error("held result changed");

	// The input side only stalls behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> res_valid && res_stall)
		else $error("input stalled without a held result");

	// A transfer that meets no stall comes out as a result. Reset must have stayed inactive and
	// the pipeline must have moved at every edge in between.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) && $past(arst_n, 4)
			&& $past(src_valid && !src_stall, 4)
			&& !$past(src_stall, 3) && !$past(src_stall, 2) && !$past(src_stall, 1)
		|-> res_valid)
		else $error("result missing after four cycles");

	// Identity prefix and an empty vector both pass the lanes unchanged.
	a_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) && $past(arst_n, 4)
			&& $past(src_valid && !src_stall, 4)
			&& !$past(src_stall, 3) && !$past(src_stall, 2) && !$past(src_stall, 1)
			&& (($past(prefix_word, 4) == 20'h000E4 && $past(vector_size, 4) == 3'd4)
				|| $past(vector_size, 4) == 3'd0)
		|-> out_x == $past(lane_x, 4) && out_y == $past(lane_y, 4)
			&& out_z == $past(lane_z, 4) && out_w == $past(lane_w, 4))
		else $error("pass-through lanes altered");

endmodule

bind vector_source_prefix_swizzle_core vsps_checker u_vsps_checker (.*);
`default_nettype wire

### sim/prefix_swizzle_checker.sv
// Checker for the source prefix swizzle: predicts each transfer's lanes and compares results.
`timescale 1ns / 100ps
module prefix_swizzle_checker
	import vsps_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	input  wire logic                src_stall,
	input  wire logic [PREFIX_W-1:0] prefix_word,
	input  wire logic [SIZE_W-1:0]   vector_size,
	input  wire logic [LANE_W-1:0]   lane_x,
	input  wire logic [LANE_W-1:0]   lane_y,
	input  wire logic [LANE_W-1:0]   lane_z,
	input  wire logic [LANE_W-1:0]   lane_w,
	input  wire logic                res_valid,
	input  wire logic                res_stall,
	input  wire logic [LANE_W-1:0]   out_x,
	input  wire logic [LANE_W-1:0]   out_y,
	input  wire logic [LANE_W-1:0]   out_z,
	input  wire logic [LANE_W-1:0]   out_w,
	output int                       errors,
	output int                       outstanding
);

	localparam int REPORT_LIMIT = 10;

	// Index is {abs, selector}: 0, 1, 2, 1/2, 3, 1/3, 1/4, 1/6.
	localparam logic [7:0][LANE_W-1:0] CONST_BITS = {
		32'h3E2A_AAAB, 32'h3E80_0000, 32'h3EAA_AAAB, 32'h4040_0000,
		32'h3F00_0000, 32'h4000_0000, 32'h3F80_0000, 32'h0000_0000
	};

	lane_vec_t expected_lanes[$];
	int        mismatch_count = 0;

	function automatic lane_vec_t apply_source_prefix(input logic [PREFIX_W-1:0] pfx,
			input logic [SIZE_W-1:0] size, input lane_vec_t src);
		lane_vec_t        res;
		int               active;
		logic [SEL_W-1:0] sel;
		logic             ab;
		logic             cst;
		logic             neg;
		logic [LANE_W-1:0] v;
		res = src;
		active = (size > LANE_COUNT) ? LANE_COUNT : int'(size);
		for (int i = 0; i < active; i++) begin
			sel = pfx[2*i +: 2];
			ab  = pfx[ABS_LSB + i];
			cst = pfx[CST_LSB + i];
			neg = pfx[NEG_LSB + i];
			if (cst) begin
				v = CONST_BITS[{ab, sel}];
			end else begin
				// A selector that points past the active lanes falls back to lane 0.
				if (sel >= active)
					sel = '0;
				v = src[sel];
				if (ab)
					v = v & ~SIGN_BIT;
			end
			if (neg)
				v = v ^ SIGN_BIT;
			res[i] = v;
		end
		return res;
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] %s", $time, msg);
	endfunction

	always @(posedge clk) begin
		lane_vec_t got;
		lane_vec_t want;
		string     lane_name;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				got = {out_w, out_z, out_y, out_x};
				if (expected_lanes.size() == 0) begin
					note_failure($sformatf("result with nothing expected: %h", got));
				end else begin
					want = expected_lanes.pop_front();
					for (int i = 0; i < LANE_COUNT; i++) begin
						lane_name = (i == 0) ? "x" : (i == 1) ? "y" : (i == 2) ? "z" : "w";
						if (got[i] !== want[i])
							note_failure($sformatf("out_%s: expected %08h, got %08h",
								lane_name, want[i], got[i]));
					end
				end
			end
			if (src_valid && !src_stall)
				expected_lanes.push_back(apply_source_prefix(prefix_word, vector_size,
					{lane_w, lane_z, lane_y, lane_x}));
		end
		outstanding <= expected_lanes.size();
		errors      <= mismatch_count;
	end

endmodule

### sim/tb_vector_source_prefix_swizzle_core.sv
// Testbench top for the source prefix swizzle: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_vector_source_prefix_swizzle_core
	import vsps_pkg::*;
();

	localparam int  RESET_CYCLES = 11;
	localparam int  LONG_HOLD    = 200;
	localparam int  DRAIN_CYCLES = 16;
	localparam int  LIMIT_CYCLES = 400000;
	localparam int  RANDOM_ITEMS = 630;

	localparam logic [PREFIX_W-1:0] PFX_IDENTITY = 20'h000E4;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                src_valid;
	logic                src_stall;
	logic [PREFIX_W-1:0] prefix_word;
	logic [SIZE_W-1:0]   vector_size;
	logic [LANE_W-1:0]   lane_x;
	logic [LANE_W-1:0]   lane_y;
	logic [LANE_W-1:0]   lane_z;
	logic [LANE_W-1:0]   lane_w;
	logic                res_valid;
	logic                res_stall;
	logic [LANE_W-1:0]   out_x;
	logic [LANE_W-1:0]   out_y;
	logic [LANE_W-1:0]   out_z;
	logic [LANE_W-1:0]   out_w;
	int                  errors;
	int                  outstanding;

	// Flags shared between the sender and the receiver processes, and the timeout counter.
	logic calm      = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   cycle_count = 0;

	always #6 clk = ~clk;

	vector_source_prefix_swizzle_core u_top (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall),
		.prefix_word(prefix_word), .vector_size(vector_size),
		.lane_x(lane_x), .lane_y(lane_y), .lane_z(lane_z), .lane_w(lane_w),
		.res_valid(res_valid), .res_stall(res_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w)
	);

	prefix_swizzle_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall),
		.prefix_word(prefix_word), .vector_size(vector_size),
		.lane_x(lane_x), .lane_y(lane_y), .lane_z(lane_z), .lane_w(lane_w),
		.res_valid(res_valid), .res_stall(res_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
		.errors(errors), .outstanding(outstanding)
	);

	// Mostly short gaps, now and then a long one; none at all in calm stretches.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [LANE_W-1:0] pick_lane();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 32'hFFFF_FFFF;
			4: return 32'h3F80_0000 | ($urandom_range(0, 1) << 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic transfer_item(input logic [PREFIX_W-1:0] pfx, input logic [SIZE_W-1:0] size,
			input logic [LANE_W-1:0] x, input logic [LANE_W-1:0] y,
			input logic [LANE_W-1:0] z, input logic [LANE_W-1:0] w);
		int gap;
		src_valid   <= 1'b1;
		prefix_word <= pfx;
		vector_size <= size;
		lane_x      <= x;
		lane_y      <= y;
		lane_z      <= z;
		lane_w      <= w;
		do
			@(posedge clk);
		while (src_stall);
		gap = gap_length();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic transfer_random_item();
		logic [PREFIX_W-1:0] pfx;
		logic [SIZE_W-1:0]   size;
		int                  r;
		pfx = PREFIX_W'($urandom);
		r = $urandom_range(0, 9);
		if (r < 3)
			pfx[CST_LSB +: 4] = '0;
		else if (r < 5)
			pfx = PFX_IDENTITY | (pfx & 20'hF0F00);
		r = $urandom_range(0, 19);
		if (r == 0)
			size = '0;
		else if (r == 1)
			size = SIZE_W'($urandom_range(5, 7));
		else
			size = SIZE_W'($urandom_range(1, 4));
		transfer_item(pfx, size, pick_lane(), pick_lane(), pick_lane(), pick_lane());
	endtask

	// Result side: random stall runs, plus one long hold-off when asked for.
	initial begin
		int stall_len;
		int open_len;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = (hold_req && !hold_done) ? LONG_HOLD : gap_length();
			open_len = $urandom_range(1, 12);
			if (stall_len > 0) begin
				res_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
				if (stall_len == LONG_HOLD)
					hold_done = 1'b1;
			end
			res_stall <= 1'b0;
			repeat (open_len) @(posedge clk);
		end
	end

	initial begin
		@(posedge clk);
		while (cycle_count < LIMIT_CYCLES) begin
			cycle_count++;
			@(posedge clk);
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		src_valid   = 1'b0;
		prefix_word = '0;
		vector_size = '0;
		lane_x      = '0;
		lane_y      = '0;
		lane_z      = '0;
		lane_w      = '0;
		arst_n      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity prefix on ordinary and extreme lane values.
		transfer_item(PFX_IDENTITY, 3'd4, 32'h3F80_0000, 32'hC000_0000, 32'h7FFF_FFFF,
			32'h8000_0000);
		transfer_item(PFX_IDENTITY, 3'd4, 32'h0, 32'h0, 32'h0, 32'h0);
		transfer_item(PFX_IDENTITY, 3'd4, '1, '1, '1, '1);
		// Reversed order, broadcast of w.
		transfer_item(20'h0001B, 3'd4, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
			32'h4444_4444);
		transfer_item(20'h000FF, 3'd4, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
			32'hC444_4444);
		// Abs, negate, and both, on source lanes.
		transfer_item(20'h00FE4, 3'd4, 32'hBF80_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h0);
		transfer_item(20'hF00E4, 3'd4, 32'hBF80_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h0);
		transfer_item(20'hF0FE4, 3'd4, 32'hBF80_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h0);
		// All eight constants, plain and negated; negated zero gives minus zero.
		transfer_item(20'h0F0E4, 3'd4, '1, '1, '1, '1);
		transfer_item(20'h0FFE4, 3'd4, '1, '1, '1, '1);
		transfer_item(20'hFF0E4, 3'd4, 32'h0, 32'h0, 32'h0, 32'h0);
		transfer_item(20'hFFFE4, 3'd4, 32'h0, 32'h0, 32'h0, 32'h0);
		// Selectors past the active size fall back to lane 0.
		transfer_item(20'h0000F, 3'd2, 32'hAAAA_0000, 32'hBBBB_0000, 32'hCCCC_0000,
			32'hDDDD_0000);
		transfer_item(20'h0003F, 3'd3, 32'hAAAA_0000, 32'hBBBB_0000, 32'hCCCC_0000,
			32'hDDDD_0000);
		// Inactive lanes pass through; size zero passes everything.
		transfer_item(20'hFFFFF, 3'd1, 32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF,
			32'h8000_0000);
		transfer_item(20'hFFFFF, 3'd0, 32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF,
			32'h8000_0000);
		transfer_item(PFX_IDENTITY, 3'd1, '1, '1, '1, '1);
		// Sizes above the lane count clamp to four.
		transfer_item(20'h0001B, 3'd5, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
			32'h4444_4444);
		transfer_item(20'hFF0E4, 3'd6, '1, '1, '1, '1);
		transfer_item(20'hAAAAA, 3'd7, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0, '1);
		transfer_item(20'h55555, 3'd4, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0, '1);
		transfer_item(20'h00000, 3'd4, 32'hC040_0000, 32'h7FFF_FFFE, 32'h0, '1);

		// Let the pipeline drain completely before the random part.
		src_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				calm = 1'b1;
			if (n == 400) begin
				calm = 1'b0;
				hold_req = 1'b1;
			end
			// Offer back to back in the calm stretch and while the result side holds off, so the block fills.
			calm = (n >= 300 && n < 400) || (n >= 400 && !hold_done);
			transfer_random_item();
		end

		src_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### vector_source_prefix_swizzle_core.f
hw/rtl/vsps_pkg.sv
hw/rtl/vsps_decode.sv
hw/rtl/vsps_lane.sv
hw/rtl/vector_source_prefix_swizzle_core.sv
hw/rtl/vsps_checker.sv
sim/prefix_swizzle_checker.sv
sim/tb_vector_source_prefix_swizzle_core.sv
